@@ design/lcdcur_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdcur_pkg
// shared types, codes and display constants for the character display
// cursor command sequencer
// ----------------------------------------------------------------------------
package lcdcur_pkg;

  // request codes
  localparam logic [2:0] REQ_PUT_CHAR  = 3'd0;
  localparam logic [2:0] REQ_CLEAR     = 3'd1;
  localparam logic [2:0] REQ_CLEAR_EOL = 3'd2;
  localparam logic [2:0] REQ_UP        = 3'd3;
  localparam logic [2:0] REQ_DOWN      = 3'd4;
  localparam logic [2:0] REQ_LEFT      = 3'd5;
  localparam logic [2:0] REQ_RIGHT     = 3'd6;
  localparam logic [2:0] REQ_SET_POS   = 3'd7;

  // write kinds
  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // display bytes
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] ADDR_LINE1 = 8'h80;
  localparam logic [7:0] ADDR_LINE2 = 8'hC0;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // cursor positions
  localparam logic [5:0] POS_HOME      = 6'd0;
  localparam logic [5:0] POS_LINE2     = 6'd16;
  localparam logic [5:0] POS_LAST_CELL = 6'd31;
  localparam logic [5:0] POS_LINE1_END = 6'd15;
  localparam logic [3:0] COL_LAST      = 4'hF;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic       target_row;
    logic [3:0] target_column;
  } req_t;

  typedef struct packed {
    logic [1:0] write_kind;
    logic [7:0] out_byte;
    logic [5:0] cursor_now;
    logic       last;
  } rsp_t;

  // one result-producing step of the datapath
  typedef enum logic [3:0] {
    UOP_PUTC,
    UOP_WRAP,
    UOP_NOWRITE,
    UOP_CLR1,
    UOP_CLR2,
    UOP_SPACE,
    UOP_EOL_ADDR,
    UOP_UP,
    UOP_DOWN,
    UOP_LEFT,
    UOP_RIGHT
  } uop_e;

  typedef struct packed {
    logic load;   // capture request, preset space counter
    logic issue;  // produce one result into the output register
    uop_e uop;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic past_end;
    logic at_line1_end;
    logic eol_last;
    logic need_down;
    logic need_up;
    logic col_gt;
    logic col_lt;
    logic col_near;
  } dp_status_t;

endpackage

@@ design/lcdcur_dp.sv @@
// ----------------------------------------------------------------------------
// lcdcur_dp
// cursor register, request register, space counter and result register
// ----------------------------------------------------------------------------
module lcdcur_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcdcur_pkg::req_t       in_data_i,
  input  lcdcur_pkg::dp_cmd_t    cmd_i,
  output lcdcur_pkg::dp_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lcdcur_pkg::rsp_t       out_data_o
);
  import lcdcur_pkg::*;

  logic [5:0] cursor_q, cursor_d;
  req_t       req_q;
  logic [3:0] cnt_q;
  logic       out_valid_q;
  rsp_t       out_q;

  logic [3:0] col, eff_col;
  logic       past;
  logic [1:0] kind;
  logic [7:0] byte_val;
  logic [7:0] cell_addr;

  assign col     = cursor_q[3:0];
  assign past    = cursor_q[5];
  assign eff_col = past ? 4'd0 : col;

  always_comb begin
    cursor_d = cursor_q;
    kind     = KIND_INSTR;
    byte_val = 8'h00;
    case (cmd_i.uop)
      UOP_PUTC: begin
        cursor_d = cursor_q + 6'd1;
        kind     = KIND_DATA;
        byte_val = req_q.char_code;
      end
      UOP_WRAP:     byte_val = ADDR_LINE2;
      UOP_NOWRITE:  kind = KIND_NONE;
      UOP_CLR1: begin
        cursor_d = POS_HOME;
        byte_val = CMD_CLEAR;
      end
      UOP_CLR2: begin
        cursor_d = POS_HOME;
        byte_val = ADDR_LINE1;
      end
      UOP_SPACE: begin
        kind     = KIND_DATA;
        byte_val = SPACE_CHAR;
      end
      UOP_EOL_ADDR: byte_val = (cursor_q[5] | cursor_q[4]) ? (ADDR_LINE2 | {4'h0, col})
                                                           : (ADDR_LINE1 | {4'h0, col});
      UOP_UP:    cursor_d = {2'b00, eff_col};
      UOP_DOWN:  cursor_d = POS_LINE2 + {2'b00, eff_col};
      UOP_LEFT:  cursor_d = (past || cursor_q == POS_HOME) ? POS_LAST_CELL : cursor_q - 6'd1;
      UOP_RIGHT: cursor_d = (cursor_q >= POS_LAST_CELL) ? POS_HOME : cursor_q + 6'd1;
      default: ;
    endcase
    cell_addr = cursor_d[4] ? (ADDR_LINE2 | {4'h0, cursor_d[3:0]})
                            : (ADDR_LINE1 | {4'h0, cursor_d[3:0]});
    if (cmd_i.uop == UOP_UP || cmd_i.uop == UOP_DOWN ||
        cmd_i.uop == UOP_LEFT || cmd_i.uop == UOP_RIGHT) begin
      byte_val = cell_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= POS_HOME;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        cursor_q    <= cursor_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
      cnt_q <= col;
    end else if (cmd_i.issue && cmd_i.uop == UOP_SPACE) begin
      cnt_q <= cnt_q + 4'd1;
    end
    if (cmd_i.issue) begin
      out_q.write_kind <= kind;
      out_q.out_byte   <= byte_val;
      out_q.cursor_now <= cursor_d;
      out_q.last       <= cmd_i.last;
    end
  end

  assign status_o.slot_free    = !out_valid_q || out_ready_i;
  assign status_o.past_end     = past;
  assign status_o.at_line1_end = (cursor_q == POS_LINE1_END);
  assign status_o.eol_last     = (cnt_q == COL_LAST);
  assign status_o.need_down    = req_q.target_row && (!cursor_q[4] || cursor_q[5]);
  assign status_o.need_up      = !req_q.target_row && (cursor_q[4] || cursor_q[5]);
  assign status_o.col_gt       = eff_col > req_q.target_column;
  assign status_o.col_lt       = eff_col < req_q.target_column;
  assign status_o.col_near     = (({1'b0, eff_col} + 5'd1) == {1'b0, req_q.target_column}) ||
                                 (({1'b0, req_q.target_column} + 5'd1) == {1'b0, eff_col});

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/lcdcur_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcdcur_ctrl
// command state machine, one datapath step per free output slot
// ----------------------------------------------------------------------------
module lcdcur_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             req_type_i,
  input  lcdcur_pkg::dp_status_t status_i,
  output lcdcur_pkg::dp_cmd_t    cmd_o
);
  import lcdcur_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUTC,
    ST_WRAP,
    ST_CLR1,
    ST_CLR2,
    ST_SPACE,
    ST_EOL_ADDR,
    ST_MOVE,
    ST_SET_LINE,
    ST_SET_COL
  } state_e;

  state_e state_q, state_d;
  uop_e   move_q, move_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    move_d      = move_q;
    cmd_o.load  = 1'b0;
    cmd_o.issue = 1'b0;
    cmd_o.uop   = UOP_NOWRITE;
    cmd_o.last  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (req_type_i)
            REQ_PUT_CHAR:  state_d = ST_PUTC;
            REQ_CLEAR:     state_d = ST_CLR1;
            REQ_CLEAR_EOL: state_d = ST_SPACE;
            REQ_UP: begin
              state_d = ST_MOVE;
              move_d  = UOP_UP;
            end
            REQ_DOWN: begin
              state_d = ST_MOVE;
              move_d  = UOP_DOWN;
            end
            REQ_LEFT: begin
              state_d = ST_MOVE;
              move_d  = UOP_LEFT;
            end
            REQ_RIGHT: begin
              state_d = ST_MOVE;
              move_d  = UOP_RIGHT;
            end
            REQ_SET_POS:   state_d = ST_SET_LINE;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUTC: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          if (status_i.past_end) begin
            cmd_o.uop = UOP_NOWRITE;
            state_d   = ST_IDLE;
          end else begin
            cmd_o.uop  = UOP_PUTC;
            cmd_o.last = !status_i.at_line1_end;
            state_d    = status_i.at_line1_end ? ST_WRAP : ST_IDLE;
          end
        end
      end
      ST_WRAP: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = UOP_WRAP;
          state_d     = ST_IDLE;
        end
      end
      ST_CLR1: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = UOP_CLR1;
          cmd_o.last  = 1'b0;
          state_d     = ST_CLR2;
        end
      end
      ST_CLR2: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = UOP_CLR2;
          state_d     = ST_IDLE;
        end
      end
      ST_SPACE: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = UOP_SPACE;
          cmd_o.last  = 1'b0;
          if (status_i.eol_last) begin
            state_d = ST_EOL_ADDR;
          end
        end
      end
      ST_EOL_ADDR: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = UOP_EOL_ADDR;
          state_d     = ST_IDLE;
        end
      end
      ST_MOVE: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = move_q;
          state_d     = ST_IDLE;
        end
      end
      ST_SET_LINE: begin
        if (status_i.need_down || status_i.need_up) begin
          if (status_i.slot_free) begin
            cmd_o.issue = 1'b1;
            cmd_o.uop   = status_i.need_down ? UOP_DOWN : UOP_UP;
            // the column is unchanged by a line move
            cmd_o.last  = !status_i.col_gt && !status_i.col_lt;
            state_d     = cmd_o.last ? ST_IDLE : ST_SET_COL;
          end
        end else if (!status_i.col_gt && !status_i.col_lt) begin
          if (status_i.slot_free) begin
            cmd_o.issue = 1'b1;
            cmd_o.uop   = UOP_NOWRITE;
            state_d     = ST_IDLE;
          end
        end else begin
          state_d = ST_SET_COL;
        end
      end
      ST_SET_COL: begin
        if (status_i.slot_free) begin
          cmd_o.issue = 1'b1;
          cmd_o.uop   = status_i.col_gt ? UOP_LEFT : UOP_RIGHT;
          cmd_o.last  = status_i.col_near;
          if (status_i.col_near) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      move_q  <= UOP_UP;
    end else begin
      state_q <= state_d;
      move_q  <= move_d;
    end
  end

endmodule

@@ design/char_lcd_cursor_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_cursor_command_sequencer
// cursor tracking and byte write sequencing for a 16x2 character display
// ----------------------------------------------------------------------------
// The block keeps the cursor of a two-line, sixteen-column character display
// (cells 0..31, 32 meaning run past the last cell) and turns each command into
// a sequence of result transfers, one display byte each, marked as instruction
// write, data write or no write, with the cursor after that byte and a last
// flag on the final transfer of the command. One command is handled at a time:
// a command is taken when the block is idle, then the controller produces one
// result per cycle into the output register while the output side keeps up.
// A command gives one result per display byte: one for a single move, two
// for clear, up to sixteen spaces and an address write for clear to end of
// line, and a line move plus up to fifteen column moves for set position.
// The sequencing state machine is what bounds the rate; output stalls hold
// it up.
// ----------------------------------------------------------------------------
module char_lcd_cursor_command_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lcdcur_pkg::req_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lcdcur_pkg::rsp_t out_data_o
);
  import lcdcur_pkg::*;

  // controller to datapath step command, datapath flags back
  dp_cmd_t    cmd;
  dp_status_t status;

  // state machine: picks one step per free output slot
  lcdcur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (in_data_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // cursor, request capture, space counter and the output register
  lcdcur_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the character display cursor command sequencer:
// a directed pass over every command and the cursor corner cases, then random
// command traffic with random gaps and stalls on both sides, back-to-back
// traffic and one long output stall; every result transfer is checked against
// a cycle-free model of the cursor and the display writes it causes
// ----------------------------------------------------------------------------
module testbench;
  import lcdcur_pkg::*;

  // cursor value once the last cell has been written
  localparam logic [5:0] POS_PAST_END = 6'd32;
  // overall run limit in ns
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  char_lcd_cursor_command_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // model state: cursor of the display as the block should see it
  logic [5:0]  cursor_track = POS_HOME;
  // writes of the command being predicted, then all writes still owed
  rsp_t        cmd_writes[$];
  rsp_t        due_writes_q[$];
  int unsigned bad_writes = 0;

  // traffic shaping knobs, changed by the test tasks
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned rx_hold_cycles = 0;
  int unsigned rx_wait = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // cursor / write prediction
  // --------------------------------------------------------------------------

  // ddram address of a cell: line one at 0x80, line two at 0xC0
  function automatic logic [7:0] cell_address(input logic [5:0] pos);
    return (pos < POS_LINE2) ? (ADDR_LINE1 | {4'h0, pos[3:0]})
                             : (ADDR_LINE2 | {4'h0, pos[3:0]});
  endfunction

  // every write carries the cursor as it stands once the write is done
  function automatic void add_write(input logic [1:0] kind, input logic [7:0] data);
    rsp_t w;
    w.write_kind = kind;
    w.out_byte   = data;
    w.cursor_now = cursor_track;
    w.last       = 1'b0;
    cmd_writes.push_back(w);
  endfunction

  function automatic void move_cursor(input logic [5:0] pos);
    cursor_track = pos;
    add_write(KIND_INSTR, cell_address(pos));
  endfunction

  function automatic void step_up();
    move_cursor({2'b00, cursor_track[3:0]});
  endfunction

  // past the end lands on the first cell of line two
  function automatic void step_down();
    logic [3:0] col;
    col = (cursor_track >= POS_PAST_END) ? 4'h0 : cursor_track[3:0];
    move_cursor(POS_LINE2 | {2'b00, col});
  endfunction

  function automatic void step_left();
    move_cursor((cursor_track > POS_HOME) ? cursor_track - 6'd1 : POS_LAST_CELL);
  endfunction

  function automatic void step_right();
    move_cursor((cursor_track < POS_LAST_CELL) ? cursor_track + 6'd1 : POS_HOME);
  endfunction

  function automatic void predict_display_writes(input req_t r);
    logic [3:0] col;
    rsp_t       w;
    int         i;
    cmd_writes.delete();
    case (r.req_type)
      REQ_PUT_CHAR: begin
        // ignored once the cursor has run past the last cell
        if (cursor_track < POS_PAST_END) begin
          cursor_track = cursor_track + 6'd1;
          add_write(KIND_DATA, r.char_code);
          if (cursor_track == POS_LINE2) add_write(KIND_INSTR, ADDR_LINE2);
        end
      end
      REQ_CLEAR: begin
        cursor_track = POS_HOME;
        add_write(KIND_INSTR, CMD_CLEAR);
        add_write(KIND_INSTR, ADDR_LINE1);
      end
      REQ_CLEAR_EOL: begin
        // past the end counts as column 0 of line two
        col = cursor_track[3:0];
        for (i = int'(col); i <= int'(COL_LAST); i++) add_write(KIND_DATA, SPACE_CHAR);
        add_write(KIND_INSTR, (cursor_track < POS_LINE2) ? cell_address(cursor_track)
                                                         : (ADDR_LINE2 | {4'h0, col}));
      end
      REQ_UP:    step_up();
      REQ_DOWN:  step_down();
      REQ_LEFT:  step_left();
      REQ_RIGHT: step_right();
      default: begin
        // line move first, past the end always takes one
        if (r.target_row && (cursor_track < POS_LINE2 || cursor_track >= POS_PAST_END))
          step_down();
        else if (!r.target_row && cursor_track >= POS_LINE2)
          step_up();
        col = cursor_track[3:0];
        while (col > r.target_column) begin
          step_left();
          col--;
        end
        while (col < r.target_column) begin
          step_right();
          col++;
        end
      end
    endcase
    if (cmd_writes.size() == 0) add_write(KIND_NONE, 8'h00);
    w = cmd_writes[cmd_writes.size() - 1];
    w.last = 1'b1;
    cmd_writes[cmd_writes.size() - 1] = w;
    foreach (cmd_writes[k]) due_writes_q.push_back(cmd_writes[k]);
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
    bad_writes++;
    if (bad_writes <= 10)
      $display("[%0t] %s: expected kind %0d byte %02h cursor %0d last %0b",
               $realtime, what, want.write_kind, want.out_byte, want.cursor_now, want.last,
               " / got kind %0d byte %02h cursor %0d last %0b",
               got.write_kind, got.out_byte, got.cursor_now, got.last);
  endtask

  // input transfers feed the model, output transfers are checked in order;
  // the input side goes first so nothing depends on process order
  always @(posedge clk_i) begin : transfer_monitor
    rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_display_writes(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (due_writes_q.size() == 0) begin
          flag_mismatch("result with nothing outstanding", '0, out_data_o);
        end else begin
          want = due_writes_q.pop_front();
          if (out_data_o.write_kind !== want.write_kind ||
              out_data_o.out_byte   !== want.out_byte   ||
              out_data_o.cursor_now !== want.cursor_now ||
              out_data_o.last       !== want.last)
            flag_mismatch("result mismatch", want, out_data_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output side: random stall per transfer, plus an optional long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_sink
    if (rx_hold_cycles != 0) begin
      // long hold-off so the block backs up into its input
      rx_hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      // transfer at this edge, draw the stall before the next one
      rx_wait = rx_idle_en ? $urandom_range(0, 15) : 0;
      out_ready_i <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_ready_i <= (rx_wait == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // input side: one command per call, returns at the edge of its transfer
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [2:0] kind, input logic [7:0] ch, input logic row,
                          input logic [3:0] col);
    req_t        item;
    int unsigned gap;
    item.req_type      = kind;
    item.char_code     = ch;
    item.target_row    = row;
    item.target_column = col;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // valid stays up across back-to-back commands, only the payload changes
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every command plus the line-end, wrap and past-end corner cases
  task automatic test_directed();
    send_req(REQ_CLEAR,     8'h5A, 1'b1, 4'hA);
    send_req(REQ_PUT_CHAR,  8'h00, 1'b0, 4'h0);  // cursor 1
    send_req(REQ_PUT_CHAR,  8'hFF, 1'b1, 4'hF);  // cursor 2
    send_req(REQ_CLEAR_EOL, 8'h00, 1'b0, 4'h0);  // fourteen spaces
    send_req(REQ_SET_POS,   8'h00, 1'b0, 4'hF);  // right moves to 15
    send_req(REQ_CLEAR_EOL, 8'h00, 1'b0, 4'h0);  // one space only
    send_req(REQ_PUT_CHAR,  8'h7E, 1'b0, 4'h0);  // line wrap to 16
    send_req(REQ_SET_POS,   8'h00, 1'b1, 4'hF);  // cursor 31
    send_req(REQ_PUT_CHAR,  8'hA5, 1'b0, 4'h0);  // runs past the end
    send_req(REQ_PUT_CHAR,  8'h41, 1'b0, 4'h0);  // ignored
    send_req(REQ_CLEAR_EOL, 8'h00, 1'b0, 4'h0);  // past end: sixteen spaces
    send_req(REQ_LEFT,      8'h00, 1'b0, 4'h0);  // past end to 31
    send_req(REQ_RIGHT,     8'h00, 1'b0, 4'h0);  // 31 wraps to 0
    send_req(REQ_LEFT,      8'h00, 1'b0, 4'h0);  // 0 wraps to 31
    send_req(REQ_PUT_CHAR,  8'h55, 1'b0, 4'h0);
    send_req(REQ_RIGHT,     8'h00, 1'b0, 4'h0);  // past end to 0
    send_req(REQ_SET_POS,   8'h00, 1'b0, 4'h0);  // already there
    send_req(REQ_SET_POS,   8'h00, 1'b1, 4'h0);  // line move only
    send_req(REQ_SET_POS,   8'h00, 1'b0, 4'hF);  // up then fifteen rights
    send_req(REQ_SET_POS,   8'h00, 1'b0, 4'h0);  // fifteen lefts
    send_req(REQ_SET_POS,   8'h00, 1'b1, 4'hF);  // down then fifteen rights
    send_req(REQ_PUT_CHAR,  8'hAA, 1'b0, 4'h0);
    send_req(REQ_DOWN,      8'h00, 1'b0, 4'h0);  // past end to 16
    send_req(REQ_SET_POS,   8'h00, 1'b1, 4'hF);
    send_req(REQ_PUT_CHAR,  8'h33, 1'b0, 4'h0);
    send_req(REQ_SET_POS,   8'h00, 1'b0, 4'h4);  // past end, up then rights
    send_req(REQ_SET_POS,   8'h00, 1'b1, 4'hF);
    send_req(REQ_PUT_CHAR,  8'hCC, 1'b0, 4'h0);
    send_req(REQ_UP,        8'h00, 1'b0, 4'h0);  // past end to 0
  endtask

  // random commands, with runs that fill line two and go past the end
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    logic [3:0]  col;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        col   = 4'($urandom_range(12, 15));
        burst = $urandom_range(2, 6);
        send_req(REQ_SET_POS, 8'($urandom_range(0, 255)), 1'b1, col);
        repeat (burst)
          send_req(REQ_PUT_CHAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)));
        // puts beyond the end of line two are dropped by the block
        sent += 1 + ((burst < 16 - col) ? burst : 16 - col);
      end else begin
        send_req((pick < 40) ? REQ_PUT_CHAR : 3'($urandom_range(0, 7)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
        sent++;
      end
    end
  endtask

  // no gaps and no stalls on either side
  task automatic test_back_to_back(input int unsigned n_items);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(n_items);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // output held off for a long stretch while commands keep coming
  task automatic test_output_stall();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 300;
    test_random_traffic(10);
    tx_idle_en     = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(120);
    test_back_to_back(60);
    test_output_stall();
    test_random_traffic(130);

    in_valid_i <= 1'b0;
    // let the last command's writes be queued before the drain check
    @(posedge clk_i);
    // drain, then a margin so a stray extra result would still be seen
    while (due_writes_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (bad_writes == 0) begin
      $display("PASS char_lcd_cursor_command_sequencer");
    end else begin
      $display("FAIL char_lcd_cursor_command_sequencer");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL char_lcd_cursor_command_sequencer");
    $finish;
  end

endmodule
